@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the neighbour list checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define KNAI_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define KNAI_ASSERT_NEXT(label, ck, rn, pre, post, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/knai_pkg.sv @@
// ----------------------------------------------------------------------------
// knai_pkg
// Types and constants for the k-nearest agent insertion list.
// ----------------------------------------------------------------------------
package knai_pkg;

    localparam int CMD_W      = 2;
    localparam int ID_W       = 16;
    localparam int COORD_W    = 16;
    localparam int RAD_W      = 12;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUMSQ_W    = SQ_W + 1;
    localparam int DIST_W     = 17;
    localparam int RADII_W    = RAD_W + 1;
    localparam int GAP_W      = 33;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 33;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELF_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_IDENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_RANGE = 3'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2
    } knai_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_GAPSQ,
        ST_INSERT,
        ST_RANGE,
        ST_EMIT,
        ST_READ
    } knai_state_t;

    typedef struct packed {
        logic             insert;
        logic             rotate;
        logic [GAP_W-1:0] gsq;
        logic [ID_W-1:0]  ident;
    } knai_cell_ctrl_t;

endpackage

@@ hw/rtl/k_nearest_agent_insert.sv @@
// ----------------------------------------------------------------------------
// k_nearest_agent_insert
// Sorted list of the nearest agents to one query agent, held in a chain of
// cells; candidates are scored by squared gap and inserted in order.
// ----------------------------------------------------------------------------
// channel | signals                              | transfer
// cfg     | cfg_we, cfg_index, cfg_data          | write on cfg_we, no wait
// in      | in_valid/in_ready + command, cand_*  | valid/ready transaction
// out     | out_valid/out_ready + result fields  | valid/ready transaction
//
// Offer: square, sum, square root, gap squared and insert, then a range
// refresh when the list fills; the square root unit runs 17 digit steps.
// Begin, unused codes and skipped candidates go straight to the result.
// Read out: the chain rotates once all round, emitting the held entries.
// Output stalls hold the sequencer; the next transaction is taken while a
// result still waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module k_nearest_agent_insert
    import knai_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 16
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_W-1:0]       command,
    input  logic [ID_W-1:0]        cand_ident,
    input  logic signed [COORD_W-1:0] cand_x,
    input  logic signed [COORD_W-1:0] cand_y,
    input  logic [RAD_W-1:0]       cand_radius,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   accepted,
    output logic                   entry_valid,
    output logic [ID_W-1:0]        neighbor_ident,
    output logic [GAP_W-1:0]       neighbor_gap_sq,
    output logic [CNT_W-1:0]       list_count,
    output logic [GAP_W-1:0]       range_now,
    output logic                   last
);

    localparam int ROT_W = $clog2(MAX_NEIGHBORS + 1);

    // configuration
    logic signed [COORD_W-1:0] self_x_reg, self_y_reg;
    logic [RAD_W-1:0]          self_radius_reg;
    logic [ID_W-1:0]           self_ident_reg;
    logic [CNT_W-1:0]          cap_reg;
    logic [GAP_W-1:0]          start_range_reg;

    // control
    knai_state_t      state_reg, state_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [GAP_W-1:0] range_reg, range_next;
    logic             acc_reg, acc_next;
    logic [ROT_W-1:0] rot_reg, rot_next;

    // datapath
    logic [ID_W-1:0]          cand_ident_reg;
    logic [RAD_W-1:0]         cand_radius_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dx_calc, dy_calc;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [SUMSQ_W-1:0]       sum_sq;
    logic [RADII_W-1:0]       radii;
    logic [DIST_W-1:0]        root_dist;
    logic [DIST_W-1:0]        gap_calc, gap_reg;
    logic [2*DIST_W-1:0]      gap_prod;
    logic [GAP_W-1:0]         gsq_reg;
    logic                     sqrt_start, sqrt_done;

    logic [CNT_W-1:0] cap_eff, fill_cnt, tail_cnt, tail_pos;
    logic             offer_skip, out_free;
    logic             cell_insert, cell_rotate;
    knai_cell_ctrl_t  cell_ctrl;

    logic [GAP_W-1:0] cell_gap   [MAX_NEIGHBORS];
    logic [ID_W-1:0]  cell_ident [MAX_NEIGHBORS];
    logic             cell_lt    [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] tail_hot;
    logic [GAP_W-1:0] tail_gap;

    // result register
    logic             res_valid_reg, res_valid_next;
    logic             res_acc_reg, res_acc_next;
    logic             res_entry_reg, res_entry_next;
    logic [ID_W-1:0]  res_ident_reg, res_ident_next;
    logic [GAP_W-1:0] res_gap_reg, res_gap_next;
    logic             res_last_reg, res_last_next;
    logic [CNT_W-1:0] res_count_reg;
    logic [GAP_W-1:0] res_range_reg;
    logic             res_load;

    // ---------------- configuration port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_x_reg      <= '0;
            self_y_reg      <= '0;
            self_radius_reg <= '0;
            self_ident_reg  <= '0;
            cap_reg         <= CAP_RESET;
            start_range_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SELF_X:      self_x_reg      <= cfg_data[COORD_W-1:0];
                REG_SELF_Y:      self_y_reg      <= cfg_data[COORD_W-1:0];
                REG_SELF_RADIUS: self_radius_reg <= cfg_data[RAD_W-1:0];
                REG_SELF_IDENT:  self_ident_reg  <= cfg_data[ID_W-1:0];
                REG_CAP:         cap_reg         <= cfg_data[CNT_W-1:0];
                REG_START_RANGE: start_range_reg <= cfg_data[GAP_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- scoring datapath ----------------
    assign dx_calc = $signed({cand_x[COORD_W-1], cand_x})
                   - $signed({self_x_reg[COORD_W-1], self_x_reg});
    assign dy_calc = $signed({cand_y[COORD_W-1], cand_y})
                   - $signed({self_y_reg[COORD_W-1], self_y_reg});
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign sum_sq   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign radii    = {1'b0, self_radius_reg} + {1'b0, cand_radius_reg};
    assign gap_calc = (root_dist > DIST_W'(radii)) ? root_dist - DIST_W'(radii) : '0;
    assign gap_prod = gap_reg * gap_reg;

    knai_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_sq),
        .done     (sqrt_done),
        .root     (root_dist)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            cand_ident_reg  <= cand_ident;
            cand_radius_reg <= cand_radius;
            dx_reg          <= dx_calc;
            dy_reg          <= dy_calc;
        end
        if (state_reg == ST_SQUARE)
        begin
            sqx_reg <= sqx_full[SQ_W-1:0];
            sqy_reg <= sqy_full[SQ_W-1:0];
        end
        if (state_reg == ST_ROOT && sqrt_done)
            gap_reg <= gap_calc;
        if (state_reg == ST_GAPSQ)
            gsq_reg <= gap_prod[GAP_W-1:0];
    end

    // ---------------- list bookkeeping ----------------
    assign cap_eff    = (32'(cap_reg) > MAX_NEIGHBORS) ? CNT_W'(MAX_NEIGHBORS) : cap_reg;
    assign offer_skip = (cand_ident == self_ident_reg) || (cap_eff == '0);
    assign fill_cnt   = (held_reg < cap_eff) ? held_reg + 1'b1 : held_reg;
    assign tail_cnt   = (state_reg == ST_INSERT) ? fill_cnt : held_reg;
    assign tail_pos   = tail_cnt - 1'b1;
    assign out_free   = !res_valid_reg || out_ready;

    assign cell_ctrl.insert = cell_insert;
    assign cell_ctrl.rotate = cell_rotate;
    assign cell_ctrl.gsq    = gsq_reg;
    assign cell_ctrl.ident  = cand_ident_reg;

    for (genvar i = 0; i < MAX_NEIGHBORS; i++)
    begin : g_cell
        assign tail_hot[i] = (32'(tail_pos) == i);

        knai_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .is_tail     (tail_hot[i]),
            .left_lt     ((i == 0) ? 1'b0 : cell_lt[(i + MAX_NEIGHBORS - 1) % MAX_NEIGHBORS]),
            .left_gap    (cell_gap[(i + MAX_NEIGHBORS - 1) % MAX_NEIGHBORS]),
            .left_ident  (cell_ident[(i + MAX_NEIGHBORS - 1) % MAX_NEIGHBORS]),
            .right_gap   (cell_gap[(i + 1) % MAX_NEIGHBORS]),
            .right_ident (cell_ident[(i + 1) % MAX_NEIGHBORS]),
            .gap         (cell_gap[i]),
            .ident       (cell_ident[i]),
            .lt          (cell_lt[i])
        );
    end

    // pick the farthest held entry
    always_comb
    begin
        tail_gap = '0;
        for (int i = 0; i < MAX_NEIGHBORS; i++)
            tail_gap = tail_gap | ({GAP_W{tail_hot[i]}} & cell_gap[i]);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            range_reg <= '0;
            acc_reg   <= 1'b0;
            rot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            range_reg <= range_next;
            acc_reg   <= acc_next;
            rot_reg   <= rot_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        range_next     = range_reg;
        acc_next       = acc_reg;
        rot_next       = rot_reg;
        sqrt_start     = 1'b0;
        cell_insert    = 1'b0;
        cell_rotate    = 1'b0;
        res_load       = 1'b0;
        res_acc_next   = acc_reg;
        res_entry_next = 1'b0;
        res_ident_next = '0;
        res_gap_next   = '0;
        res_last_next  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next = 1'b0;
                    rot_next = '0;
                    unique case (knai_cmd_t'(command))
                        CMD_BEGIN:
                        begin
                            held_next  = '0;
                            range_next = start_range_reg;
                            state_next = ST_EMIT;
                        end
                        CMD_OFFER:
                            state_next = offer_skip ? ST_EMIT : ST_SQUARE;
                        CMD_READ:
                            state_next = (held_reg == '0) ? ST_EMIT : ST_READ;
                        default:
                            state_next = ST_EMIT;
                    endcase
                end
            end
            ST_SQUARE:
                state_next = ST_SUM;
            ST_SUM:
            begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                    state_next = ST_GAPSQ;
            end
            ST_GAPSQ:
                state_next = ST_INSERT;
            ST_INSERT:
            begin
                if (gsq_reg < range_reg)
                begin
                    cell_insert = 1'b1;
                    held_next   = fill_cnt;
                    acc_next    = 1'b1;
                    state_next  = (fill_cnt >= cap_eff) ? ST_RANGE : ST_EMIT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RANGE:
            begin
                // list full: range shrinks to the farthest entry
                range_next = tail_gap;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // rotate the whole chain once, emitting the held entries from the head
                if (32'(rot_reg) < 32'(held_reg))
                begin
                    if (out_free)
                    begin
                        res_load       = 1'b1;
                        res_acc_next   = 1'b0;
                        res_entry_next = 1'b1;
                        res_ident_next = cell_ident[0];
                        res_gap_next   = cell_gap[0];
                        res_last_next  = (32'(rot_reg) + 1) == 32'(held_reg);
                        cell_rotate    = 1'b1;
                        rot_next       = rot_reg + 1'b1;
                    end
                end
                else
                begin
                    cell_rotate = 1'b1;
                    rot_next    = rot_reg + 1'b1;
                end
                if (cell_rotate && rot_reg == ROT_W'(MAX_NEIGHBORS - 1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- result register ----------------
    assign res_valid_next = res_load ? 1'b1 : (out_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_acc_reg   <= res_acc_next;
            res_entry_reg <= res_entry_next;
            res_ident_reg <= res_ident_next;
            res_gap_reg   <= res_gap_next;
            res_last_reg  <= res_last_next;
            res_count_reg <= held_reg;
            res_range_reg <= range_reg;
        end
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = res_valid_reg;
    assign accepted        = res_acc_reg;
    assign entry_valid     = res_entry_reg;
    assign neighbor_ident  = res_ident_reg;
    assign neighbor_gap_sq = res_gap_reg;
    assign list_count      = res_count_reg;
    assign range_now       = res_range_reg;
    assign last            = res_last_reg;

endmodule

@@ hw/rtl/knai_sqrt.sv @@
// ----------------------------------------------------------------------------
// knai_sqrt
// Floored integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module knai_sqrt
    import knai_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUMSQ_W-1:0] radicand,
    output logic               done,
    output logic [DIST_W-1:0]  root
);

    localparam int ACC_W = SUMSQ_W + 1;
    localparam logic [ACC_W-1:0] BIT_TOP = ACC_W'(1) << (2 * (DIST_W - 1));

    logic [SUMSQ_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0]   root_reg, root_next;
    logic [ACC_W-1:0]   bit_reg, bit_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [ACC_W-1:0]   trial;

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            root_next = '0;
            bit_next  = BIT_TOP;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[SUMSQ_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            // last digit pair done
            if (bit_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg[DIST_W-1:0];

endmodule

@@ hw/rtl/knai_cell.sv @@
// ----------------------------------------------------------------------------
// knai_cell
// One list slot: holds a squared gap and an identifier, compares the offered
// gap against its own and shifts, loads or rotates as the chain directs.
// ----------------------------------------------------------------------------
module knai_cell
    import knai_pkg::*;
(
    input  logic             clk,
    input  knai_cell_ctrl_t  ctrl,
    input  logic             is_tail,
    input  logic             left_lt,
    input  logic [GAP_W-1:0] left_gap,
    input  logic [ID_W-1:0]  left_ident,
    input  logic [GAP_W-1:0] right_gap,
    input  logic [ID_W-1:0]  right_ident,
    output logic [GAP_W-1:0] gap,
    output logic [ID_W-1:0]  ident,
    output logic             lt
);

    logic [GAP_W-1:0] gap_reg, gap_next;
    logic [ID_W-1:0]  ident_reg, ident_next;

    assign lt = ctrl.gsq < gap_reg;

    always_comb
    begin
        gap_next   = gap_reg;
        ident_next = ident_reg;
        if (ctrl.rotate)
        begin
            gap_next   = right_gap;
            ident_next = right_ident;
        end
        else if (ctrl.insert)
        begin
            // newcomer sits in front of the left slot: take the left entry
            if (left_lt)
            begin
                gap_next   = left_gap;
                ident_next = left_ident;
            end
            else if (is_tail || lt)
            begin
                gap_next   = ctrl.gsq;
                ident_next = ctrl.ident;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg   <= gap_next;
        ident_reg <= ident_next;
    end

    assign gap   = gap_reg;
    assign ident = ident_reg;

endmodule

@@ hw/rtl/knai_checker.sv @@
// ----------------------------------------------------------------------------
// knai_checker
// Port-level checks for the neighbour list, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module knai_checker
    import knai_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 16
)(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      accepted,
    input logic                      entry_valid,
    input logic [ID_W-1:0]           neighbor_ident,
    input logic [GAP_W-1:0]          neighbor_gap_sq,
    input logic [CNT_W-1:0]          list_count,
    input logic [GAP_W-1:0]          range_now,
    input logic                      last
);

    `KNAI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(neighbor_gap_sq) && $stable(neighbor_ident) && $stable(range_now) && $stable(last), "stalled result changed")
    `KNAI_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "new transaction taken while the last one is in progress")
    `KNAI_ASSERT(a_entry_not_accept, clk, rst_n, out_valid && entry_valid |-> !accepted && list_count != 0 && 32'(list_count) <= MAX_NEIGHBORS, "list entry with bad flags or count")
    `KNAI_ASSERT(a_single_last, clk, rst_n, out_valid && !entry_valid |-> last, "non-entry result not final")

endmodule

bind k_nearest_agent_insert knai_checker #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_knai_checker (.*);
